// File: rtl/lsrpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrpe_pkg : shared definitions of the led strip rainbow pattern engine
// Field widths, command and mode codes, register indexes, color word type.
// ----------------------------------------------------------------------------
package lsrpe_pkg;

  // field widths
  localparam int unsigned PIX_W   = 9;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned PHASE_W = 9;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  // pattern modes
  localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WAVE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SPREAD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SOLID   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OFF     = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 3'd5;

  // target color source
  localparam logic [1:0] TGT_WHEEL = 2'd0;
  localparam logic [1:0] TGT_SOLID = 2'd1;
  localparam logic [1:0] TGT_OFF   = 2'd2;

  // wheel segment bounds and phase limits
  localparam logic [CH_W-1:0]    WHEEL_SEG1 = 8'd85;
  localparam logic [CH_W-1:0]    WHEEL_SEG2 = 8'd170;
  localparam logic [CH_W-1:0]    CH_MAX     = 8'd255;
  localparam logic [PHASE_W-1:0] PHASE_TOP  = 9'd256;

  // reset values of the registers
  localparam logic [CH_W-1:0]  BRIGHT_RST = 8'd100;
  localparam logic [LEN_W-1:0] LENGTH_RST = 10'd300;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

// File: rtl/led_strip_rainbow_pattern_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_rainbow_pattern_engine : per-pixel color wheel pattern engine
// Pixel colors live in one synchronous memory, updated by a three-stage
// read-modify-write pipeline with forwarding of pending and last writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid / in_stall) carry a command and a pixel index.
//   A pixel command moves each channel of that pixel one step toward the
//   pattern target; a frame command advances the phase (256 wraps to 0).
//   Every input word gives exactly one output word (out_valid / out_stall)
//   with the index, the pixel's new color and the phase after the word.
//   out_valid rises once the word has passed the stage a, stage c and output
//   registers; while in_stall and out_stall are low, one word per cycle is
//   taken and delivered, also for back-to-back updates of the same pixel.
//   The whole pipeline, from input to the output register, moves together:
//   while out_stall holds a waiting word, in_stall is raised.
//   Configuration writes (cfg_valid / cfg_ready) are taken in any cycle and
//   belong to idle periods between words.
//   After reset a clearing pass writes zero to all MAX_PIXELS memory entries,
//   one per cycle; in_stall stays high meanwhile.
//   Reset also zeroes the phase and loads the register reset values.
// ----------------------------------------------------------------------------
module led_strip_rainbow_pattern_engine
  import lsrpe_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  logic [PIX_W-1:0]      in_pixel_index,
  // output words
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_index,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  output logic [PHASE_W-1:0]    out_phase,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);
  localparam logic [12:0]   DEPTH13   = 13'(MAX_PIXELS);

  // configuration registers
  logic [MODE_W-1:0] mode_r;
  logic [CH_W-1:0]   bright_r;
  logic [LEN_W-1:0]  length_r;
  logic [CH_W-1:0]   solid_red_r;
  logic [CH_W-1:0]   solid_green_r;
  logic [CH_W-1:0]   solid_blue_r;

  assign cfg_ready = 1'b1;

  // register write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_RAINBOW;
      bright_r      <= BRIGHT_RST;
      length_r      <= LENGTH_RST;
      solid_red_r   <= '0;
      solid_green_r <= '0;
      solid_blue_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:   mode_r        <= cfg_data[MODE_W-1:0];
        REG_BRIGHT: bright_r      <= cfg_data[CH_W-1:0];
        REG_LENGTH: length_r      <= cfg_data[LEN_W-1:0];
        REG_RED:    solid_red_r   <= cfg_data[CH_W-1:0];
        REG_GREEN:  solid_green_r <= cfg_data[CH_W-1:0];
        REG_BLUE:   solid_blue_r  <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline enable and input handshake
  logic out_valid_r;
  logic clearing_r;
  logic en;
  logic accept;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en || clearing_r;
  assign accept   = in_valid && !in_stall;

  // clearing pass after reset
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == LAST_ADDR) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // frame phase
  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;

  assign phase_nxt = (phase_r >= PHASE_TOP) ? '0 : phase_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (accept && in_command == CMD_FRAME) begin
      phase_r <= phase_nxt;
    end
  end

  // stage a: coverage, target source and wheel index
  logic [LEN_W-1:0]  p_ext;
  logic [PIX_W-1:0]  half;
  logic [LEN_W-1:0]  two_half;
  logic [LEN_W-1:0]  far_dist;
  logic [LEN_W-1:0]  pos;
  logic              in_range;
  logic              covered;
  logic              wheel;
  logic              change;
  logic [1:0]        tgt_sel;
  logic [CH_W-1:0]   wheel_idx;

  assign p_ext    = {1'b0, in_pixel_index};
  assign half     = length_r[LEN_W-1:1];
  assign two_half = {half, 1'b0};
  assign far_dist = length_r - p_ext;
  assign in_range = {4'b0, in_pixel_index} < DEPTH13;
  assign covered  = p_ext < length_r;

  always_comb begin
    wheel   = 1'b0;
    change  = 1'b0;
    tgt_sel = TGT_OFF;
    pos     = p_ext;
    if (covered) begin
      case (mode_r)
        MODE_RAINBOW: begin
          wheel = 1'b1;
        end
        MODE_WAVE: begin
          if (p_ext < two_half) begin
            wheel = 1'b1;
            if (in_pixel_index < half) begin
              pos = {1'b0, half - 1'b1 - in_pixel_index};
            end else begin
              pos = {1'b0, in_pixel_index - half};
            end
          end
        end
        MODE_SPREAD: begin
          wheel = 1'b1;
          pos   = (p_ext <= far_dist) ? p_ext : far_dist;
        end
        MODE_SOLID: begin
          change  = 1'b1;
          tgt_sel = TGT_SOLID;
        end
        MODE_OFF: begin
          change  = 1'b1;
          tgt_sel = TGT_OFF;
        end
        default: ;
      endcase
      if (wheel && phase_r < PHASE_TOP) begin
        change  = 1'b1;
        tgt_sel = TGT_WHEEL;
      end
    end
  end

  assign wheel_idx = pos[CH_W-1:0] + phase_r[CH_W-1:0];

  logic               a_valid_r;
  logic               a_cmd_r;
  logic [PIX_W-1:0]   a_pix_r;
  logic               a_in_range_r;
  logic               a_change_r;
  logic [1:0]         a_sel_r;
  logic [CH_W-1:0]    a_idx_r;
  logic [PHASE_W-1:0] a_phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_cmd_r      <= in_command;
      a_pix_r      <= in_pixel_index;
      a_in_range_r <= in_range;
      a_change_r   <= change;
      a_sel_r      <= tgt_sel;
      a_idx_r      <= wheel_idx;
      a_phase_r    <= (in_command == CMD_FRAME) ? phase_nxt : phase_r;
    end
  end

  // pixel memory with one write and one read port
  rgb_t          pix_mem [MAX_PIXELS];
  rgb_t          rd_data_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  rgb_t          wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pix_mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_data_r <= pix_mem[AW'(in_pixel_index)];
    end
  end

  // last write, kept for forwarding
  logic          lw_valid_r;
  logic [AW-1:0] lw_addr_r;
  rgb_t          lw_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (wr_en) begin
      lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr_r <= wr_addr;
      lw_data_r <= wr_data;
    end
  end

  // stage b: wheel color, target scaling products, current color
  logic [CH_W-1:0] seg_off;
  logic [CH_W-1:0] off3;
  rgb_t            base;

  always_comb begin
    if (a_idx_r < WHEEL_SEG1) begin
      seg_off = a_idx_r;
    end else if (a_idx_r < WHEEL_SEG2) begin
      seg_off = a_idx_r - WHEEL_SEG1;
    end else begin
      seg_off = a_idx_r - WHEEL_SEG2;
    end
    off3 = CH_W'({1'b0, seg_off, 1'b0} + {2'b0, seg_off});
    base = '0;
    case (a_sel_r)
      TGT_WHEEL: begin
        if (a_idx_r < WHEEL_SEG1) begin
          base.red   = off3;
          base.green = CH_MAX - off3;
        end else if (a_idx_r < WHEEL_SEG2) begin
          base.red   = CH_MAX - off3;
          base.blue  = off3;
        end else begin
          base.green = off3;
          base.blue  = CH_MAX - off3;
        end
      end
      TGT_SOLID: begin
        base.red   = solid_red_r;
        base.green = solid_green_r;
        base.blue  = solid_blue_r;
      end
      default: base = '0;
    endcase
  end

  // stage c signals used for forwarding
  logic               c_valid_r;
  logic               c_cmd_r;
  logic [PIX_W-1:0]   c_pix_r;
  logic               c_in_range_r;
  logic               c_change_r;
  logic [PHASE_W-1:0] c_phase_r;
  logic [15:0]        c_prod_r [3];
  rgb_t               c_cur_r;
  rgb_t               c_new;
  logic               c_pix_live;

  // current color: pending stage c result, then last write, then memory
  rgb_t b_cur;

  assign c_pix_live = c_valid_r && c_cmd_r == CMD_PIXEL && c_in_range_r;

  always_comb begin
    if (c_pix_live && AW'(c_pix_r) == AW'(a_pix_r)) begin
      b_cur = c_new;
    end else if (lw_valid_r && lw_addr_r == AW'(a_pix_r)) begin
      b_cur = lw_data_r;
    end else begin
      b_cur = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_cmd_r      <= a_cmd_r;
      c_pix_r      <= a_pix_r;
      c_in_range_r <= a_in_range_r;
      c_change_r   <= a_change_r;
      c_phase_r    <= a_phase_r;
      c_prod_r[0]  <= {8'b0, base.red}   * {8'b0, bright_r};
      c_prod_r[1]  <= {8'b0, base.green} * {8'b0, bright_r};
      c_prod_r[2]  <= {8'b0, base.blue}  * {8'b0, bright_r};
      c_cur_r      <= b_cur;
    end
  end

  // stage c: divide by 255 and step toward the target
  logic [CH_W-1:0] tgt [3];
  logic [CH_W-1:0] cur_ch [3];
  logic [CH_W-1:0] new_ch [3];
  logic [16:0]     q_sum [3];

  assign cur_ch[0] = c_cur_r.red;
  assign cur_ch[1] = c_cur_r.green;
  assign cur_ch[2] = c_cur_r.blue;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q_sum[k] = {1'b0, c_prod_r[k]} + {9'b0, c_prod_r[k][15:8]} + 17'd1;
      tgt[k]   = q_sum[k][15:8];
      if (!c_change_r) begin
        new_ch[k] = cur_ch[k];
      end else if (tgt[k] > cur_ch[k]) begin
        new_ch[k] = cur_ch[k] + 1'b1;
      end else if (tgt[k] < cur_ch[k]) begin
        new_ch[k] = cur_ch[k] - 1'b1;
      end else begin
        new_ch[k] = cur_ch[k];
      end
    end
  end

  assign c_new = '{red: new_ch[0], green: new_ch[1], blue: new_ch[2]};

  // write port: clearing pass, else stage c write-back
  always_comb begin
    if (clearing_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else begin
      wr_en   = en && c_pix_live && c_change_r;
      wr_addr = AW'(c_pix_r);
      wr_data = c_new;
    end
  end

  // output register
  logic [PIX_W-1:0]   out_index_r;
  rgb_t               out_rgb_r;
  logic [PHASE_W-1:0] out_phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_phase_r <= c_phase_r;
      if (c_cmd_r == CMD_FRAME) begin
        out_index_r <= '0;
        out_rgb_r   <= '0;
      end else begin
        out_index_r <= c_pix_r;
        out_rgb_r   <= c_in_range_r ? c_new : '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_red   = out_rgb_r.red;
  assign out_green = out_rgb_r.green;
  assign out_blue  = out_rgb_r.blue;
  assign out_phase = out_phase_r;

endmodule

// File: tb/lsrpe_color_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrpe_color_checker : scoreboard of the led strip rainbow pattern engine
// Watches the input, output and configuration channels, keeps its own copy
// of the pixel colors, frame phase and registers, predicts one output word
// per accepted input word and compares each accepted output word, field by
// field, with the oldest prediction. Failures and pending words go to the top.
// ----------------------------------------------------------------------------
module lsrpe_color_checker
  import lsrpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_command,
  input  logic [PIX_W-1:0]      in_pixel_index,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [PIX_W-1:0]      out_index,
  input  logic [CH_W-1:0]       out_red,
  input  logic [CH_W-1:0]       out_green,
  input  logic [CH_W-1:0]       out_blue,
  input  logic [PHASE_W-1:0]    out_phase,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           fail_cnt,
  output int unsigned           words_due
);

  localparam int unsigned STRIP_DEPTH = 1 << PIX_W;

  typedef struct packed {
    logic [PIX_W-1:0]   index;
    rgb_t               color;
    logic [PHASE_W-1:0] phase;
  } led_word_t;

  // shadow state of the engine
  rgb_t               color_mem [STRIP_DEPTH];
  logic [PHASE_W-1:0] wheel_phase;
  logic [MODE_W-1:0]  mode_q;
  logic [CH_W-1:0]    bright_q;
  logic [LEN_W-1:0]   strip_len;
  rgb_t               solid_q;

  led_word_t   pending_words [$];
  int unsigned miss_cnt;

  // brightness scaling, floor(v * brightness / 255)
  function automatic logic [CH_W-1:0] dim(input logic [CH_W-1:0] v);
    return CH_W'((int'(v) * int'(bright_q)) / int'(CH_MAX));
  endfunction

  // color wheel, three linear segments
  function automatic rgb_t wheel_rgb(input logic [CH_W-1:0] w);
    rgb_t            c;
    logic [CH_W-1:0] d;
    if (w < WHEEL_SEG1) begin
      c.red   = CH_W'(w * 3);
      c.green = CH_MAX - CH_W'(w * 3);
      c.blue  = '0;
    end else if (w < WHEEL_SEG2) begin
      d       = w - WHEEL_SEG1;
      c.red   = CH_MAX - CH_W'(d * 3);
      c.green = '0;
      c.blue  = CH_W'(d * 3);
    end else begin
      d       = w - WHEEL_SEG2;
      c.red   = '0;
      c.green = CH_W'(d * 3);
      c.blue  = CH_MAX - CH_W'(d * 3);
    end
    return c;
  endfunction

  // one step of slew toward the target
  function automatic logic [CH_W-1:0] step_toward(input logic [CH_W-1:0] now,
                                                  input logic [CH_W-1:0] goal);
    if (goal > now) return now + 1'b1;
    if (goal < now) return now - 1'b1;
    return now;
  endfunction

  // predicted output word of one input word, updates the shadow state
  function automatic led_word_t next_pixel_word(input logic cmd,
                                                input logic [PIX_W-1:0] idx);
    led_word_t   res;
    rgb_t        now;
    rgb_t        goal;
    int unsigned p;
    int unsigned n;
    int unsigned half;
    int unsigned pos;
    logic        on_wheel;
    logic        moves;
    res      = '0;
    goal     = '0;
    pos      = 0;
    on_wheel = 1'b0;
    moves    = 1'b0;
    if (cmd == CMD_FRAME) begin
      wheel_phase = (wheel_phase >= PHASE_TOP) ? '0 : wheel_phase + 1'b1;
      res.phase   = wheel_phase;
      return res;
    end
    // every 9-bit index lies inside the store
    p    = 32'(idx);
    n    = 32'(strip_len);
    half = n / 2;
    now  = color_mem[idx];
    if (p < n) begin
      case (mode_q)
        MODE_RAINBOW: begin
          on_wheel = 1'b1;
          pos      = p;
        end
        MODE_WAVE: begin
          // odd strip leaves its last pixel out
          if (p < 2 * half) begin
            on_wheel = 1'b1;
            pos      = (p < half) ? (half - 1 - p) : (p - half);
          end
        end
        MODE_SPREAD: begin
          on_wheel = 1'b1;
          pos      = (p <= n - p) ? p : (n - p);
        end
        MODE_SOLID: begin
          goal.red   = dim(solid_q.red);
          goal.green = dim(solid_q.green);
          goal.blue  = dim(solid_q.blue);
          moves      = 1'b1;
        end
        MODE_OFF: moves = 1'b1;
        default: ;
      endcase
    end
    // wheel modes hold the pixel at the top phase
    if (on_wheel && wheel_phase < PHASE_TOP) begin
      goal       = wheel_rgb(CH_W'(pos + wheel_phase));
      goal.red   = dim(goal.red);
      goal.green = dim(goal.green);
      goal.blue  = dim(goal.blue);
      moves      = 1'b1;
    end
    if (moves) begin
      now.red        = step_toward(now.red, goal.red);
      now.green      = step_toward(now.green, goal.green);
      now.blue       = step_toward(now.blue, goal.blue);
      color_mem[idx] = now;
    end
    res.index = idx;
    res.color = now;
    res.phase = wheel_phase;
    return res;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      miss_cnt++;
    end
  endfunction

  // sample all channels at the clock edge
  always @(posedge clk) begin
    led_word_t want;
    if (!rst_n) begin
      for (int k = 0; k < STRIP_DEPTH; k++) color_mem[k] = '0;
      wheel_phase = '0;
      mode_q      = MODE_RAINBOW;
      bright_q    = BRIGHT_RST;
      strip_len   = LENGTH_RST;
      solid_q     = '0;
      miss_cnt    = 0;
      pending_words.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:   mode_q        = cfg_data[MODE_W-1:0];
          REG_BRIGHT: bright_q      = cfg_data[CH_W-1:0];
          REG_LENGTH: strip_len     = cfg_data[LEN_W-1:0];
          REG_RED:    solid_q.red   = cfg_data[CH_W-1:0];
          REG_GREEN:  solid_q.green = cfg_data[CH_W-1:0];
          REG_BLUE:   solid_q.blue  = cfg_data[CH_W-1:0];
          default: ;
        endcase
      end
      // accepted input word
      if (in_valid && !in_stall)
        pending_words.push_back(next_pixel_word(in_command, in_pixel_index));
      // accepted output word
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          $error("output word with no pending prediction, index %0d", out_index);
          miss_cnt++;
        end else begin
          want = pending_words.pop_front();
          check_field("out_index", 32'(want.index), 32'(out_index));
          check_field("red", 32'(want.color.red), 32'(out_red));
          check_field("green", 32'(want.color.green), 32'(out_green));
          check_field("blue", 32'(want.color.blue), 32'(out_blue));
          check_field("phase", 32'(want.phase), 32'(out_phase));
        end
      end
    end
    fail_cnt  <= miss_cnt;
    words_due <= pending_words.size();
  end

endmodule

// File: tb/led_strip_rainbow_pattern_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_rainbow_pattern_engine_tb : top of the pattern engine testbench
// Drives a short directed sequence, then a series of register settings, each
// followed by frame advances and sweeps over the strip with random noise and,
// outside calm phases, random idling on both channels. The checker beside the
// block compares every output word; this module gives the verdict.
// ----------------------------------------------------------------------------
module led_strip_rainbow_pattern_engine_tb;
  import lsrpe_pkg::*;

  localparam int unsigned NUM_PHASES      = 18;
  localparam int unsigned WORDS_PER_PHASE = 105;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned QUIET_LIMIT     = 5000;

  // unused mode codes, the block leaves pixels as they are
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_command = CMD_PIXEL;
  logic [PIX_W-1:0]      in_pixel_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      out_index;
  logic [CH_W-1:0]       out_red;
  logic [CH_W-1:0]       out_green;
  logic [CH_W-1:0]       out_blue;
  logic [PHASE_W-1:0]    out_phase;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int unsigned           fail_cnt;
  int unsigned           words_due;

  logic                  tx_gaps_on = 1'b0;
  logic                  rx_gaps_on = 1'b0;
  int unsigned           rx_hold = 0;
  int unsigned           quiet_cyc = 0;
  int unsigned           frame_pos = 0;
  int unsigned           cur_len = 32'(LENGTH_RST);

  led_strip_rainbow_pattern_engine u_top (.*);

  lsrpe_color_checker u_check (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // output side stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold   <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      if (rx_hold == 1) out_stall <= 1'b0;
    end else if (rx_gaps_on && $urandom_range(0, 6) == 0) begin
      out_stall <= 1'b1;
      rx_hold   <= $urandom_range(1, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cyc <= 0;
    else
      quiet_cyc <= quiet_cyc + 1;
  end

  initial begin
    wait (quiet_cyc >= QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  // one input word, with an optional idle burst ahead of it
  task automatic send_word(input logic cmd, input logic [PIX_W-1:0] idx);
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_pixel_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_FRAME) frame_pos = (frame_pos >= PHASE_TOP) ? 0 : frame_pos + 1;
  endtask

  // stop sending and let every pending word come out
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(input logic [MODE_W-1:0] mode, input logic [CH_W-1:0] bright,
                               input logic [LEN_W-1:0] len, input logic [CH_W-1:0] r,
                               input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
    write_reg(REG_MODE, CFG_DATA_W'(mode));
    write_reg(REG_BRIGHT, CFG_DATA_W'(bright));
    write_reg(REG_LENGTH, len);
    write_reg(REG_RED, CFG_DATA_W'(r));
    write_reg(REG_GREEN, CFG_DATA_W'(g));
    write_reg(REG_BLUE, CFG_DATA_W'(b));
    cfg_valid <= 1'b0;
    cur_len = 32'(len);
  endtask

  // frame advances and sweeps over the strip, plus noise words
  task automatic run_phase(input int unsigned n_words);
    int unsigned sent;
    int unsigned span;
    int unsigned start;
    int unsigned reps;
    int unsigned burst;
    int unsigned pick;
    sent = 0;
    span = (cur_len == 0) ? 1 : ((cur_len > 16) ? 16 : cur_len);
    while (sent < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // noise: any command, any index
        send_word(1'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 511)));
        sent++;
      end else if (pick < 24) begin
        // run of frame advances, held just below the top phase so a sweep lands there
        burst = $urandom_range(5, 40);
        for (int k = 0; k < burst && frame_pos + 1 != PHASE_TOP; k++) begin
          send_word(CMD_FRAME, PIX_W'($urandom_range(0, 511)));
          sent++;
        end
      end else begin
        send_word(CMD_FRAME, PIX_W'($urandom_range(0, 511)));
        sent++;
        start = (cur_len > span) ? $urandom_range(0, cur_len - span) : 0;
        reps  = $urandom_range(1, 3);
        for (int k = 0; k < span; k++) begin
          for (int j = 0; j < reps; j++) begin
            send_word(CMD_PIXEL, PIX_W'(start + k));
            sent++;
          end
        end
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    logic calm;
    repeat (4) @(posedge clk);
    rst_n      <= 1'b1;
    rx_gaps_on <= 1'b1;

    // directed words at the reset settings
    send_word(CMD_PIXEL, 9'd0);
    send_word(CMD_PIXEL, 9'd0);
    send_word(CMD_PIXEL, 9'd0);
    send_word(CMD_PIXEL, 9'd299);
    send_word(CMD_PIXEL, 9'd300);
    send_word(CMD_PIXEL, 9'd511);
    send_word(CMD_FRAME, 9'd511);
    send_word(CMD_PIXEL, 9'd0);
    send_word(CMD_PIXEL, 9'd299);
    send_word(CMD_FRAME, 9'd0);
    send_word(CMD_PIXEL, 9'd1);
    send_word(CMD_PIXEL, 9'd1);
    send_word(CMD_PIXEL, 9'd2);
    send_word(CMD_PIXEL, 9'd256);
    send_word(CMD_FRAME, 9'd255);
    send_word(CMD_PIXEL, 9'd511);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:  load_settings(MODE_RAINBOW, 8'd255, 10'd8, 8'd0, 8'd0, 8'd0);
        1:  load_settings(MODE_WAVE, 8'd255, 10'd7, 8'd0, 8'd0, 8'd0);
        2:  load_settings(MODE_SPREAD, 8'd0, 10'd10, 8'd0, 8'd0, 8'd0);
        3:  load_settings(MODE_SOLID, 8'd255, 10'd5, 8'd255, 8'd0, 8'd255);
        4:  load_settings(MODE_SOLID, 8'd255, 10'd3, 8'd2, 8'd1, 8'd3);
        5:  load_settings(MODE_OFF, 8'd100, 10'd512, 8'd0, 8'd0, 8'd0);
        6:  load_settings(MODE_SPARE_LO, 8'd50, 10'd6, 8'd0, 8'd0, 8'd0);
        7:  load_settings(MODE_WAVE, 8'd200, 10'd1, 8'd0, 8'd0, 8'd0);
        8:  load_settings(MODE_RAINBOW, 8'd1, 10'd0, 8'd0, 8'd0, 8'd0);
        9:  load_settings(MODE_SPREAD, 8'd255, 10'd512, 8'd255, 8'd255, 8'd255);
        10: load_settings(MODE_SPARE_HI, 8'd255, 10'd4, 8'd0, 8'd0, 8'd0);
        11: load_settings(MODE_WAVE, 8'd255, 10'd2, 8'd0, 8'd0, 8'd0);
        12: load_settings(MODE_RAINBOW, 8'd1, 10'd4, 8'd0, 8'd0, 8'd0);
        default: begin
          // random settings, mostly short strips so pixels see many steps
          load_settings(MODE_W'($urandom_range(0, 4)), CH_W'($urandom_range(0, 255)),
                        ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(17, 512))
                                                    : LEN_W'($urandom_range(1, 16)),
                        CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                        CH_W'($urandom_range(0, 255)));
        end
      endcase
      // no idling in the last phases, and now and then a calm phase
      calm = (ph >= NUM_PHASES - 2) || ($urandom_range(0, 4) == 0);
      tx_gaps_on = !calm;
      rx_gaps_on <= !calm;
      run_phase(WORDS_PER_PHASE);
      drain();
    end

    if (fail_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: led_strip_rainbow_pattern_engine.f
rtl/lsrpe_pkg.sv
rtl/led_strip_rainbow_pattern_engine.sv
tb/lsrpe_color_checker.sv
tb/led_strip_rainbow_pattern_engine_tb.sv
